// ----- hdl/lkv_pkg.sv -----
// -----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key-value cache: default sizes,
// operation and register codes, sequencer states and scan control groups.
// -----------------------------------------------------------------------------
package lkv_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    // Configuration port.
    localparam int APB_AW = 2;
    localparam int APB_DW = 32;
    localparam int CAP_W  = 5;

    localparam logic [APB_AW-1:0] REG_CAPACITY = 2'd0;
    localparam logic [CAP_W-1:0]  CAP_RESET    = 5'd16;

    // Operation codes carried in the func field.
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_WRITE  = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_RESP   = 4'b1000
    } t_state;

    // Control from the sequencer to the scan unit.
    typedef struct packed {
        logic clear;
        logic cmp_en;
        logic cmp_valid;
    } t_scan_ctl;

    // Status from the scan unit back to the sequencer.
    typedef struct packed {
        logic hit;
        logic lru_seen;
        logic free_found;
    } t_scan_flags;

endpackage

// ----- hdl/lkv_req_if.sv -----
// -----------------------------------------------------------------------------
// lkv_req_if
// Request channel: one lookup or write operation per transaction.
// -----------------------------------------------------------------------------
interface lkv_req_if #(
    parameter int KEY_W = lkv_pkg::KEY_WIDTH_DEF,
    parameter int VAL_W = lkv_pkg::VALUE_WIDTH_DEF
) ();
    logic                    valid;
    logic                    ready;
    logic                    func;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output func, output key, output value, input ready);
    modport sink   (input valid, input func, input key, input value, output ready);
endinterface

// ----- hdl/lkv_rsp_if.sv -----
// -----------------------------------------------------------------------------
// lkv_rsp_if
// Response channel: hit flag, read value and eviction report per transaction.
// -----------------------------------------------------------------------------
interface lkv_rsp_if #(
    parameter int KEY_W = lkv_pkg::KEY_WIDTH_DEF,
    parameter int VAL_W = lkv_pkg::VALUE_WIDTH_DEF
) ();
    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;

    modport source (output valid, output hit, output read_value, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input hit, input read_value, input evicted,
                    input evicted_key, output ready);
endinterface

// ----- hdl/lkv_ram.sv -----
// -----------------------------------------------------------------------------
// lkv_ram
// Generic single-port RAM with synchronous write and registered read.
// -----------------------------------------------------------------------------
module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/lkv_scan.sv -----
// -----------------------------------------------------------------------------
// lkv_scan
// Shared compare unit. One entry per cycle it checks the stored key against
// the requested key, the entry's rank against the oldest rank, and the valid
// bit for the first free slot, and keeps what it finds for the update step.
// -----------------------------------------------------------------------------
module lkv_scan #(
    parameter int IDX_W = 4,
    parameter int KEY_W = 32,
    parameter int VAL_W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lkv_pkg::t_scan_ctl   i_ctl,
    input  logic [IDX_W-1:0]     i_cmp_idx,
    input  logic [IDX_W-1:0]     i_cmp_rank,
    input  logic [IDX_W-1:0]     i_lru_rank,
    input  logic [KEY_W-1:0]     i_key,
    input  logic [KEY_W-1:0]     i_rd_key,
    input  logic [VAL_W-1:0]     i_rd_val,
    output lkv_pkg::t_scan_flags o_flags,
    output logic [IDX_W-1:0]     o_hit_idx,
    output logic [IDX_W-1:0]     o_hit_rank,
    output logic [VAL_W-1:0]     o_hit_val,
    output logic [IDX_W-1:0]     o_lru_idx,
    output logic [KEY_W-1:0]     o_lru_key,
    output logic [IDX_W-1:0]     o_free_idx
);

    lkv_pkg::t_scan_flags r_flags;
    logic [IDX_W-1:0]     r_hit_idx;
    logic [IDX_W-1:0]     r_hit_rank;
    logic [VAL_W-1:0]     r_hit_val;
    logic [IDX_W-1:0]     r_lru_idx;
    logic [KEY_W-1:0]     r_lru_key;
    logic [IDX_W-1:0]     r_free_idx;

    logic w_key_eq;
    logic w_is_lru;
    logic w_is_free;

    // The one comparator set shared by every entry of the scan.
    assign w_key_eq  = i_ctl.cmp_en && i_ctl.cmp_valid && (i_rd_key == i_key);
    assign w_is_lru  = i_ctl.cmp_en && i_ctl.cmp_valid && (i_cmp_rank == i_lru_rank);
    assign w_is_free = i_ctl.cmp_en && !i_ctl.cmp_valid && !r_flags.free_found;

    // Status flags restart with each new operation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_ctl.clear) begin
            r_flags <= '0;
        end else begin
            if (w_key_eq) begin
                r_flags.hit <= 1'b1;
            end
            if (w_is_lru) begin
                r_flags.lru_seen <= 1'b1;
            end
            if (w_is_free) begin
                r_flags.free_found <= 1'b1;
            end
        end
    end

    // Captured entry data; only meaningful where its flag is set.
    always_ff @(posedge i_clk) begin
        if (w_key_eq) begin
            r_hit_idx  <= i_cmp_idx;
            r_hit_rank <= i_cmp_rank;
            r_hit_val  <= i_rd_val;
        end
        if (w_is_lru) begin
            r_lru_idx <= i_cmp_idx;
            r_lru_key <= i_rd_key;
        end
        if (w_is_free) begin
            r_free_idx <= i_cmp_idx;
        end
    end

    assign o_flags    = r_flags;
    assign o_hit_idx  = r_hit_idx;
    assign o_hit_rank = r_hit_rank;
    assign o_hit_val  = r_hit_val;
    assign o_lru_idx  = r_lru_idx;
    assign o_lru_key  = r_lru_key;
    assign o_free_idx = r_free_idx;

endmodule

// ----- hdl/lru_key_value_cache_unit.sv -----
// -----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key-value cache with least-recently-used replacement.
// Lookups and writes are resolved by a sequential scan over all entries.
// -----------------------------------------------------------------------------
//   Channel   Direction  Handshake          Contents
//   i_req     in         valid / ready      func, key, value
//   o_rsp     out        valid / ready      hit, read_value, evicted, evicted_key
//   APB       in / out   psel/penable/pready capacity register at byte address 0
//
// Each operation goes from accepting in idle to a scan, which reads one entry
// per cycle from the key and value RAM port, then to an update of ranks and
// storage, and last to a step that hands off the result.
// Reset clears the valid bits, ranks, entry count and sets capacity to 16; the
// key and value RAMs need no clearing pass. A result waiting in the output
// register does not block the next request; a second finished result waits.
// -----------------------------------------------------------------------------
module lru_key_value_cache_unit #(
    parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_WIDTH   = lkv_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = lkv_pkg::VALUE_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    lkv_req_if.sink                    i_req,
    lkv_rsp_if.source                  o_rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lkv_pkg::APB_AW-1:0] paddr,
    input  logic [lkv_pkg::APB_DW-1:0] pwdata,
    output logic [lkv_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > lkv_pkg::CAP_W) ? CNT_W : lkv_pkg::CAP_W;

    lkv_pkg::t_state            r_state;
    logic [lkv_pkg::CAP_W-1:0]  r_capacity;
    logic                       r_func;
    logic [KEY_WIDTH-1:0]       r_key;
    logic [VALUE_WIDTH-1:0]     r_value;
    logic [CNT_W-1:0]           r_step;
    logic                       r_cmp_en;
    logic [IDX_W-1:0]           r_cmp_idx;
    logic [MAX_ENTRIES-1:0]     r_valid;
    logic [IDX_W-1:0]           r_rank [MAX_ENTRIES];
    logic [CNT_W-1:0]           r_count;

    logic                       r_res_hit;
    logic [VALUE_WIDTH-1:0]     r_res_rval;
    logic                       r_res_ev;
    logic [KEY_WIDTH-1:0]       r_res_evkey;

    logic                       r_rsp_vld;
    logic                       r_rsp_hit;
    logic [VALUE_WIDTH-1:0]     r_rsp_rval;
    logic                       r_rsp_ev;
    logic [KEY_WIDTH-1:0]       r_rsp_evkey;

    logic                       w_accept;
    logic                       w_cfg_wr;
    logic                       w_out_free;
    lkv_pkg::t_scan_ctl         w_ctl;
    lkv_pkg::t_scan_flags       w_flags;
    logic [IDX_W-1:0]           w_hit_idx;
    logic [IDX_W-1:0]           w_hit_rank;
    logic [VALUE_WIDTH-1:0]     w_hit_val;
    logic [IDX_W-1:0]           w_lru_idx;
    logic [KEY_WIDTH-1:0]       w_lru_key;
    logic [IDX_W-1:0]           w_free_idx;
    logic [CNT_W-1:0]           w_cnt_m1;
    logic [CMP_W-1:0]           w_cap_ext;
    logic [CMP_W-1:0]           w_max_ext;
    logic [CMP_W-1:0]           w_cap_eff;
    logic                       w_insert;
    logic                       w_evict;
    logic                       w_do_ins;
    logic                       w_touch;
    logic [IDX_W-1:0]           w_slot;
    logic [IDX_W-1:0]           w_ram_addr;
    logic                       w_key_we;
    logic                       w_val_we;
    logic [KEY_WIDTH-1:0]       w_rd_key;
    logic [VALUE_WIDTH-1:0]     w_rd_val;

    // Configuration port: capacity register, writes complete in the access phase.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr == lkv_pkg::REG_CAPACITY);
    assign prdata   = (paddr == lkv_pkg::REG_CAPACITY)
                    ? {{(lkv_pkg::APB_DW - lkv_pkg::CAP_W){1'b0}}, r_capacity}
                    : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lkv_pkg::CAP_RESET;
        end else if (w_cfg_wr) begin
            r_capacity <= pwdata[lkv_pkg::CAP_W-1:0];
        end
    end

    // Request handshake: a new operation enters only from idle.
    assign i_req.ready = (r_state == lkv_pkg::ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func  <= i_req.func;
            r_key   <= i_req.key;
            r_value <= i_req.value;
        end
    end

    // Effective capacity is held between one and the number of entries.
    assign w_cap_ext = CMP_W'(r_capacity);
    assign w_max_ext = CMP_W'(MAX_ENTRIES);
    always_comb begin
        if (w_cap_ext == '0) begin
            w_cap_eff = CMP_W'(1);
        end else if (w_cap_ext > w_max_ext) begin
            w_cap_eff = w_max_ext;
        end else begin
            w_cap_eff = w_cap_ext;
        end
    end

    // The oldest valid entry always holds rank count - 1.
    assign w_cnt_m1 = r_count - CNT_W'(1);

    // Shared scan unit.
    assign w_ctl.clear     = w_accept;
    assign w_ctl.cmp_en    = r_cmp_en;
    assign w_ctl.cmp_valid = r_valid[r_cmp_idx];

    lkv_scan #(
        .IDX_W (IDX_W),
        .KEY_W (KEY_WIDTH),
        .VAL_W (VALUE_WIDTH)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_cmp_idx  (r_cmp_idx),
        .i_cmp_rank (r_rank[r_cmp_idx]),
        .i_lru_rank (w_cnt_m1[IDX_W-1:0]),
        .i_key      (r_key),
        .i_rd_key   (w_rd_key),
        .i_rd_val   (w_rd_val),
        .o_flags    (w_flags),
        .o_hit_idx  (w_hit_idx),
        .o_hit_rank (w_hit_rank),
        .o_hit_val  (w_hit_val),
        .o_lru_idx  (w_lru_idx),
        .o_lru_key  (w_lru_key),
        .o_free_idx (w_free_idx)
    );

    // Decision made from the scan results.
    assign w_insert = !w_flags.hit && (r_func == lkv_pkg::FUNC_WRITE);
    assign w_evict  = w_insert && w_flags.lru_seen && (CMP_W'(r_count) >= w_cap_eff);
    assign w_do_ins = w_insert && (w_evict || w_flags.free_found);
    assign w_touch  = w_flags.hit || w_do_ins;

    always_comb begin
        if (w_flags.hit) begin
            w_slot = w_hit_idx;
        end else if (w_evict) begin
            w_slot = w_lru_idx;
        end else begin
            w_slot = w_free_idx;
        end
    end

    // Storage: the scan reads through the RAM port, the update writes through it.
    assign w_ram_addr = (r_state == lkv_pkg::ST_UPDATE) ? w_slot : r_step[IDX_W-1:0];
    assign w_key_we   = (r_state == lkv_pkg::ST_UPDATE) && w_do_ins;
    assign w_val_we   = (r_state == lkv_pkg::ST_UPDATE)
                      && (w_do_ins || (w_flags.hit && (r_func == lkv_pkg::FUNC_WRITE)));

    lkv_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (MAX_ENTRIES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_addr  (w_ram_addr),
        .i_wdata (r_key),
        .o_rdata (w_rd_key)
    );

    lkv_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (MAX_ENTRIES)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (w_val_we),
        .i_addr  (w_ram_addr),
        .i_wdata (r_value),
        .o_rdata (w_rd_val)
    );

    // Sequencer.
    assign w_out_free = !r_rsp_vld || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lkv_pkg::ST_IDLE;
            r_step   <= '0;
            r_cmp_en <= 1'b0;
        end else begin
            r_cmp_en <= 1'b0;
            case (r_state)
                lkv_pkg::ST_IDLE: begin
                    r_step <= '0;
                    if (w_accept) begin
                        r_state <= lkv_pkg::ST_SCAN;
                    end
                end
                lkv_pkg::ST_SCAN: begin
                    if (r_step == CNT_W'(MAX_ENTRIES)) begin
                        r_state <= lkv_pkg::ST_UPDATE;
                    end else begin
                        r_cmp_en <= 1'b1;
                        r_step   <= r_step + CNT_W'(1);
                    end
                end
                lkv_pkg::ST_UPDATE: begin
                    r_state <= lkv_pkg::ST_RESP;
                end
                lkv_pkg::ST_RESP: begin
                    if (w_out_free) begin
                        r_state <= lkv_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= lkv_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // The compare stage sees the entry addressed in the previous cycle.
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_step[IDX_W-1:0];
    end

    // Valid bits, recency ranks and entry count change in the update step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if ((r_state == lkv_pkg::ST_UPDATE) && w_touch) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (IDX_W'(i) == w_slot) begin
                    r_rank[i] <= '0;
                end else if (r_valid[i] && (w_do_ins || (r_rank[i] < w_hit_rank))) begin
                    r_rank[i] <= r_rank[i] + IDX_W'(1);
                end
            end
            if (w_do_ins) begin
                r_valid[w_slot] <= 1'b1;
                if (!w_evict) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
        end
    end

    // Result of the operation, held until the output register is free.
    always_ff @(posedge i_clk) begin
        if (r_state == lkv_pkg::ST_UPDATE) begin
            r_res_hit   <= w_flags.hit;
            r_res_rval  <= (w_flags.hit && (r_func == lkv_pkg::FUNC_LOOKUP)) ? w_hit_val : '0;
            r_res_ev    <= w_evict;
            r_res_evkey <= w_evict ? w_lru_key : '0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_vld <= 1'b0;
        end else if ((r_state == lkv_pkg::ST_RESP) && w_out_free) begin
            r_rsp_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == lkv_pkg::ST_RESP) && w_out_free) begin
            r_rsp_hit   <= r_res_hit;
            r_rsp_rval  <= r_res_rval;
            r_rsp_ev    <= r_res_ev;
            r_rsp_evkey <= r_res_evkey;
        end
    end

    assign o_rsp.valid       = r_rsp_vld;
    assign o_rsp.hit         = r_rsp_hit;
    assign o_rsp.read_value  = r_rsp_rval;
    assign o_rsp.evicted     = r_rsp_ev;
    assign o_rsp.evicted_key = r_rsp_evkey;

endmodule
